>>> hw/rtl/mas_pkg.sv
// mas_pkg: shared types, constants and register codes for the mapped address space access block.
// Used by every module in hw/rtl except mas_ram. It has no dependencies.
package mas_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int LANES     = 4;
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   localparam int WC_EN0 = 0;
   localparam int WC_RD0 = 1;
   localparam int WC_WR0 = 2;
   localparam int WC_EN1 = 3;
   localparam int WC_RD1 = 4;
   localparam int WC_WR1 = 5;

   localparam logic [LIMIT_W-1:0] RAM_LIMIT_RESET = LIMIT_W'(65536);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RAM_LIMIT      = 3'd0,
      REG_PRIMARY_SPACE  = 3'd1,
      REG_WIN0_START     = 3'd2,
      REG_WIN0_END       = 3'd3,
      REG_WIN1_START     = 3'd4,
      REG_WIN1_END       = 3'd5,
      REG_WINDOW_CONTROL = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] ram_limit;
      logic               primary_space;
      logic [ADDR_W-1:0]  win0_start;
      logic [ADDR_W-1:0]  win0_end;
      logic [ADDR_W-1:0]  win1_start;
      logic [ADDR_W-1:0]  win1_end;
      logic [5:0]         window_control;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic rd_go;
      logic wr_go;
      logic limited;
   } lane_ctl_type;

endpackage

>>> hw/rtl/mapped_address_space_access_top.sv
// mapped_address_space_access_top: byte-addressed store behind a two-window memory-map decoder.
// Writes are taken one beat per cycle while req_ready is high. A read beat passes through the
// registered lane RAM read into the response register; no request is taken until it is loaded.
// After reset a clearing pass zeroes every row of the store with req_ready low;
// csr writes are taken during it. Registers return to their reset values.
// Depends on mas_pkg, mas_decode, mas_lane, mas_merge.
module mapped_address_space_access_top #(
   parameter int MEM_BYTES = mas_pkg::MEM_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [1:0]                      req_access_size,
   input  logic [mas_pkg::ADDR_W-1:0]      req_addr,
   input  logic [mas_pkg::DATA_W-1:0]      req_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mas_pkg::DATA_W-1:0]      rsp_rdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mas_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   localparam int ROWS  = MEM_BYTES / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   mas_pkg::state_type    state_ff;
   mas_pkg::state_type    state_in;
   mas_pkg::cfg_type      cfg_ff;
   mas_pkg::cfg_type      cfg_in;
   logic [ROW_W-1:0]      clr_row_ff;
   logic [ROW_W-1:0]      clr_row_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [mas_pkg::DATA_W-1:0] rsp_rdata_ff;
   logic [mas_pkg::DATA_W-1:0] rsp_rdata_in;
   logic [1:0]            base_ff;
   logic                  accept;
   logic                  is_write;
   logic                  limited;
   logic                  load_rsp;
   mas_pkg::lane_ctl_type ctl;
   logic [7:0]            lane_byte [mas_pkg::LANES];
   logic [mas_pkg::DATA_W-1:0] merged;

   assign csr_ready = 1'b1;
   assign is_write  = req_cmd == mas_pkg::CMD_WRITE;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (mas_pkg::csr_index_type'(csr_index))
            mas_pkg::REG_RAM_LIMIT:
               cfg_in.ram_limit = csr_wdata[mas_pkg::LIMIT_W-1:0];
            mas_pkg::REG_PRIMARY_SPACE:  cfg_in.primary_space  = csr_wdata[0];
            mas_pkg::REG_WIN0_START:     cfg_in.win0_start     = csr_wdata[15:0];
            mas_pkg::REG_WIN0_END:       cfg_in.win0_end       = csr_wdata[15:0];
            mas_pkg::REG_WIN1_START:     cfg_in.win1_start     = csr_wdata[15:0];
            mas_pkg::REG_WIN1_END:       cfg_in.win1_end       = csr_wdata[15:0];
            mas_pkg::REG_WINDOW_CONTROL: cfg_in.window_control = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   mas_decode u_decode (
      .cfg      (cfg_ff),
      .addr     (req_addr),
      .is_write (is_write),
      .limited  (limited)
   );

   always_comb begin
      ctl.clear   = state_ff == mas_pkg::ST_CLEAR;
      ctl.rd_go   = accept && !is_write;
      ctl.wr_go   = accept && is_write;
      ctl.limited = limited;
   end

   for (genvar g = 0; g < mas_pkg::LANES; g++) begin : g_lane
      mas_lane #(
         .MEM_BYTES (MEM_BYTES),
         .LANE      (g)
      ) u_lane (
         .clock       (clock),
         .ctl         (ctl),
         .clr_row     (clr_row_ff),
         .addr        (req_addr),
         .access_size (req_access_size),
         .wdata       (req_wdata),
         .ram_limit   (cfg_ff.ram_limit),
         .rd_byte     (lane_byte[g])
      );
   end

   mas_merge u_merge (
      .lane_byte (lane_byte),
      .base      (base_ff),
      .rdata     (merged)
   );

   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      req_ready    = 1'b0;
      load_rsp     = 1'b0;
      rsp_rdata_in = rsp_rdata_ff;
      case (state_ff)
         mas_pkg::ST_CLEAR: begin
            clr_row_in = clr_row_ff + ROW_W'(1);
            if (clr_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = mas_pkg::ST_IDLE;
            end
         end
         mas_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !is_write) begin
               state_in = mas_pkg::ST_READ;
            end
         end
         mas_pkg::ST_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_rdata_in = merged;
               state_in     = mas_pkg::ST_IDLE;
            end
         end
         default: state_in = mas_pkg::ST_IDLE;
      endcase
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                  <= mas_pkg::ST_CLEAR;
         clr_row_ff                <= '0;
         rsp_valid_ff              <= 1'b0;
         cfg_ff.ram_limit          <= mas_pkg::RAM_LIMIT_RESET;
         cfg_ff.primary_space      <= 1'b1;
         cfg_ff.win0_start         <= '0;
         cfg_ff.win0_end           <= '0;
         cfg_ff.win1_start         <= '0;
         cfg_ff.win1_end           <= '0;
         cfg_ff.window_control     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rdata_ff <= rsp_rdata_in;
      if (ctl.rd_go) begin
         base_ff <= req_addr[1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rsp_rdata_ff;

endmodule

>>> hw/rtl/mas_ram.sv
// mas_ram: generic single write port, single read port RAM with registered read data.
// No dependencies.
module mas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mas_decode.sv
// mas_decode: window compare for the primary space; decides whether the RAM limit applies.
// Depends on mas_pkg.
module mas_decode (
   input  mas_pkg::cfg_type                 cfg,
   input  logic [mas_pkg::ADDR_W-1:0]       addr,
   input  logic                             is_write,
   output logic                             limited
);

   logic hit0;
   logic hit1;
   logic pass0;
   logic pass1;
   logic bypass;

   always_comb begin
      hit0  = cfg.window_control[mas_pkg::WC_EN0] &&
              (addr >= cfg.win0_start) && (addr <= cfg.win0_end);
      hit1  = cfg.window_control[mas_pkg::WC_EN1] &&
              (addr >= cfg.win1_start) && (addr <= cfg.win1_end);
      pass0 = is_write ? cfg.window_control[mas_pkg::WC_WR0]
                       : cfg.window_control[mas_pkg::WC_RD0];
      pass1 = is_write ? cfg.window_control[mas_pkg::WC_WR1]
                       : cfg.window_control[mas_pkg::WC_RD1];
      // window 0 wins even when it denies the access
      if (hit0) begin
         bypass = pass0;
      end else if (hit1) begin
         bypass = pass1;
      end else begin
         bypass = 1'b0;
      end
      limited = cfg.primary_space && !bypass;
   end

endmodule

>>> hw/rtl/mas_lane.sv
// mas_lane: one byte lane; owns every store byte whose index is LANE modulo 4.
// Depends on mas_pkg and mas_ram.
module mas_lane #(
   parameter int MEM_BYTES = mas_pkg::MEM_BYTES,
   parameter int LANE      = 0
) (
   input  logic                                         clock,
   input  mas_pkg::lane_ctl_type                        ctl,
   input  logic [((MEM_BYTES / 4 > 1) ? $clog2(MEM_BYTES / 4) : 1)-1:0] clr_row,
   input  logic [mas_pkg::ADDR_W-1:0]                   addr,
   input  logic [1:0]                                   access_size,
   input  logic [mas_pkg::DATA_W-1:0]                   wdata,
   input  logic [mas_pkg::LIMIT_W-1:0]                  ram_limit,
   output logic [7:0]                                   rd_byte
);

   localparam int ROWS  = MEM_BYTES / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW    = $clog2(MEM_BYTES);
   localparam int CMP_W = (AW > mas_pkg::LIMIT_W) ? AW : mas_pkg::LIMIT_W;

   logic [1:0]       k;
   logic [1:0]       last_k;
   logic             used;
   logic [CMP_W-1:0] sum;
   logic [AW-1:0]    idx;
   logic             open;
   logic [ROW_W-1:0] row;
   logic [7:0]       wr_byte;
   logic             ram_we;
   logic [ROW_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic [7:0]       ram_rdata;
   logic             used_ff;
   logic             open_ff;

   always_comb begin
      k = 2'(LANE) - addr[1:0];
      case (access_size)
         mas_pkg::SIZE_BYTE: last_k = 2'd0;
         mas_pkg::SIZE_WORD: last_k = 2'd1;
         default:            last_k = 2'd3;
      endcase
      used    = k <= last_k;
      sum     = CMP_W'(addr) + CMP_W'(k);
      idx     = sum[AW-1:0];
      open    = ctl.limited && (CMP_W'(idx) >= CMP_W'(ram_limit));
      row     = ROW_W'(idx >> 2);
      wr_byte = 8'(wdata >> {k, 3'b000});
      if (ctl.clear) begin
         ram_we    = 1'b1;
         ram_waddr = clr_row;
         ram_wdata = 8'h00;
      end else begin
         ram_we    = ctl.wr_go && used && !open;
         ram_waddr = row;
         ram_wdata = wr_byte;
      end
   end

   mas_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ctl.rd_go),
      .rd_addr (row),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (ctl.rd_go) begin
         used_ff <= used;
         open_ff <= open;
      end
   end

   always_comb begin
      if (!used_ff) begin
         rd_byte = 8'h00;
      end else if (open_ff) begin
         rd_byte = 8'hFF;
      end else begin
         rd_byte = ram_rdata;
      end
   end

endmodule

>>> hw/rtl/mas_merge.sv
// mas_merge: rotates the four lane bytes back into access order for the read beat.
// Depends on mas_pkg.
module mas_merge (
   input  logic [7:0]                 lane_byte [mas_pkg::LANES],
   input  logic [1:0]                 base,
   output logic [mas_pkg::DATA_W-1:0] rdata
);

   logic [1:0] sel [mas_pkg::LANES];

   always_comb begin
      for (int k = 0; k < mas_pkg::LANES; k++) begin
         sel[k] = base + 2'(k);
         rdata[8*k +: 8] = lane_byte[sel[k]];
      end
   end

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for mapped_address_space_access_top. Keeps a byte image of the
// store and a copy of the decoder registers, predicts each read beat and checks rsp in order.
// Depends on mas_pkg and the block under hw/rtl.
module tb_top;

   localparam logic       CMD_READ    = ~mas_pkg::CMD_WRITE;
   localparam logic [1:0] SIZE_DWORD  = 2'd2;
   localparam logic [1:0] SIZE_CODE3  = 2'd3;
   localparam int         GAP_MAX     = 12;
   localparam int         LONG_HOLD   = 300;
   localparam int         QUIET_LIMIT = 100000;
   localparam int         PHASES      = 16;
   localparam int         PHASE_BEATS = 100;

   typedef struct {
      logic        cmd;
      logic [1:0]  size;
      logic [15:0] addr;
      logic [31:0] wdata;
   } access_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_cmd = CMD_READ;
   logic [1:0]                     req_access_size = mas_pkg::SIZE_BYTE;
   logic [mas_pkg::ADDR_W-1:0]     req_addr = '0;
   logic [mas_pkg::DATA_W-1:0]     req_wdata = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [mas_pkg::DATA_W-1:0]     rsp_rdata;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   mas_pkg::csr_index_type         csr_index = mas_pkg::REG_RAM_LIMIT;
   logic [mas_pkg::CSR_DAT_W-1:0]  csr_wdata = '0;

   access_type       pending_access[$];
   access_type       next_access;
   logic [31:0]      rdata_due[$];
   bit   [7:0]       mem_image [mas_pkg::MEM_BYTES];
   mas_pkg::cfg_type shadow_cfg;

   bit req_took, rsp_took;
   bit req_burst = 1'b1, rsp_burst = 1'b1;
   int req_gap, rsp_pause;
   int long_hold_ask, long_hold_seen;
   int rdata_errors, quiet_cycles;

   mapped_address_space_access_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_access_size (req_access_size),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rdata       (rsp_rdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // window 0 wins over window 1; a hit without permission stops the search
   function automatic logic window_pass(logic [15:0] a, logic wr);
      logic [5:0] wc;
      wc = shadow_cfg.window_control;
      if (wc[mas_pkg::WC_EN0] && a >= shadow_cfg.win0_start && a <= shadow_cfg.win0_end)
         return wr ? wc[mas_pkg::WC_WR0] : wc[mas_pkg::WC_RD0];
      if (wc[mas_pkg::WC_EN1] && a >= shadow_cfg.win1_start && a <= shadow_cfg.win1_end)
         return wr ? wc[mas_pkg::WC_WR1] : wc[mas_pkg::WC_RD1];
      return 1'b0;
   endfunction

   function automatic logic [31:0] bus_access(access_type acc);
      int          nbytes, k;
      logic [15:0] idx;
      logic        wr, limited, open_bus;
      logic [31:0] rd;
      wr = (acc.cmd == mas_pkg::CMD_WRITE);
      nbytes = (acc.size == mas_pkg::SIZE_BYTE) ? 1 :
               (acc.size == mas_pkg::SIZE_WORD) ? 2 : 4;
      limited = shadow_cfg.primary_space && !window_pass(acc.addr, wr);
      rd = '0;
      for (k = 0; k < nbytes; k++) begin
         idx = acc.addr + 16'(k);
         open_bus = limited && ({1'b0, idx} >= shadow_cfg.ram_limit);
         if (wr) begin
            if (!open_bus)
               mem_image[idx] = acc.wdata[8*k +: 8];
         end else begin
            rd[8*k +: 8] = open_bus ? 8'hFF : mem_image[idx];
         end
      end
      return rd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg = '0;
         shadow_cfg.ram_limit = mas_pkg::RAM_LIMIT_RESET;
         shadow_cfg.primary_space = 1'b1;
         req_took = 1'b0;
         rsp_took = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_took = req_valid && req_ready;
         rsp_took = rsp_valid && rsp_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mas_pkg::REG_RAM_LIMIT:
                  shadow_cfg.ram_limit = csr_wdata[mas_pkg::LIMIT_W-1:0];
               mas_pkg::REG_PRIMARY_SPACE:
                  shadow_cfg.primary_space = csr_wdata[0];
               mas_pkg::REG_WIN0_START:
                  shadow_cfg.win0_start = csr_wdata[mas_pkg::ADDR_W-1:0];
               mas_pkg::REG_WIN0_END:
                  shadow_cfg.win0_end = csr_wdata[mas_pkg::ADDR_W-1:0];
               mas_pkg::REG_WIN1_START:
                  shadow_cfg.win1_start = csr_wdata[mas_pkg::ADDR_W-1:0];
               mas_pkg::REG_WIN1_END:
                  shadow_cfg.win1_end = csr_wdata[mas_pkg::ADDR_W-1:0];
               mas_pkg::REG_WINDOW_CONTROL:
                  shadow_cfg.window_control = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req_took) begin
            next_access.cmd = req_cmd;
            next_access.size = req_access_size;
            next_access.addr = req_addr;
            next_access.wdata = req_wdata;
            if (req_cmd == mas_pkg::CMD_WRITE)
               void'(bus_access(next_access));
            else
               rdata_due.push_back(bus_access(next_access));
         end
         if (rsp_took) begin
            if (rdata_due.size() == 0) begin
               if (rdata_errors < 10)
                  $display("rsp beat %h with no read outstanding", rsp_rdata);
               rdata_errors++;
            end else if (rsp_rdata !== rdata_due[0]) begin
               if (rdata_errors < 10)
                  $display("rdata mismatch: expected %h, got %h", rdata_due[0], rsp_rdata);
               rdata_errors++;
               void'(rdata_due.pop_front());
            end else begin
               void'(rdata_due.pop_front());
            end
         end
         if (req_took || rsp_took || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Verification failed");
               $finish;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!(req_valid && !req_took)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_access.size() != 0) begin
            next_access = pending_access.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_access.cmd;
            req_access_size <= next_access.size;
            req_addr <= next_access.addr;
            req_wdata <= next_access.wdata;
            req_gap = req_burst ? 0 : $urandom_range(0, GAP_MAX);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_pause = 0;
      end else begin
         if (long_hold_seen != long_hold_ask) begin
            long_hold_seen = long_hold_ask;
            rsp_pause = LONG_HOLD;
         end else if (rsp_took) begin
            rsp_pause = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
         end
         if (rsp_pause > 0) begin
            rsp_ready <= 1'b0;
            rsp_pause--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic post_access(logic cmd, logic [1:0] size, logic [15:0] addr,
                              logic [31:0] wdata);
      access_type acc;
      acc.cmd = cmd;
      acc.size = size;
      acc.addr = addr;
      acc.wdata = wdata;
      pending_access.push_back(acc);
   endtask

   task automatic settle();
      while (pending_access.size() != 0 || req_valid || rdata_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(mas_pkg::csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(logic [16:0] lim, logic prim, logic [15:0] w0s, logic [15:0] w0e,
                              logic [15:0] w1s, logic [15:0] w1e, logic [5:0] wc);
      settle();
      csr_write(mas_pkg::REG_RAM_LIMIT, 32'(lim));
      csr_write(mas_pkg::REG_PRIMARY_SPACE, 32'(prim));
      csr_write(mas_pkg::REG_WIN0_START, 32'(w0s));
      csr_write(mas_pkg::REG_WIN0_END, 32'(w0e));
      csr_write(mas_pkg::REG_WIN1_START, 32'(w1s));
      csr_write(mas_pkg::REG_WIN1_END, 32'(w1e));
      csr_write(mas_pkg::REG_WINDOW_CONTROL, 32'(wc));
   endtask

   task automatic random_config(int ph);
      logic [16:0] lim;
      logic [15:0] base, w0s, w0e, w1s, w1e;
      case ($urandom_range(0, 5))
         0: lim = 17'd0;
         1: lim = 17'd65536;
         2: lim = 17'($urandom_range(1, 65535));
         3: lim = 17'($urandom_range(1, 8));
         4: lim = 17'($urandom_range(65528, 65535));
         default: lim = 17'($urandom_range(16'h4000, 16'hC000));
      endcase
      base = lim[15:0] + 16'($urandom_range(0, 255)) - 16'd128;
      w0s = base + 16'($urandom_range(0, 31));
      w0e = ($urandom_range(0, 5) == 0) ? w0s - 16'($urandom_range(1, 4))
                                        : w0s + 16'($urandom_range(0, 63));
      w1s = base + 16'($urandom_range(0, 63));
      w1e = ($urandom_range(0, 5) == 0) ? w1s - 16'($urandom_range(1, 4))
                                        : w1s + 16'($urandom_range(0, 255));
      if (ph == 0)
         load_config(17'd0, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 6'h3F);
      else if (ph == 1)
         load_config(17'd65536, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h00);
      else
         load_config(lim, $urandom_range(0, 4) != 0, w0s, w0e, w1s, w1e,
                     6'($urandom_range(0, 63)));
   endtask

   // bias addresses to the limit edge, window edges, the wrap point and a hot area; some are uniform
   function automatic logic [15:0] pick_addr(logic [15:0] hot);
      case ($urandom_range(0, 7))
         0: return shadow_cfg.ram_limit[15:0] + 16'($urandom_range(0, 7)) - 16'd4;
         1: return shadow_cfg.win0_start + 16'($urandom_range(0, 5)) - 16'd3;
         2: return shadow_cfg.win0_end + 16'($urandom_range(0, 5)) - 16'd2;
         3: return shadow_cfg.win1_start + 16'($urandom_range(0, 5)) - 16'd3;
         4: return shadow_cfg.win1_end + 16'($urandom_range(0, 5)) - 16'd2;
         5: return 16'hFFFF - 16'($urandom_range(0, 4));
         6: return 16'($urandom());
         default: return hot + 16'($urandom_range(0, 63));
      endcase
   endfunction

   initial begin
      int          ph, n;
      logic [15:0] hot;

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset registers: plain store with no open bus
      post_access(CMD_READ, mas_pkg::SIZE_BYTE, 16'h0000, 32'h0);
      post_access(mas_pkg::CMD_WRITE, SIZE_DWORD, 16'h0000, 32'hFFFF_FFFF);
      post_access(CMD_READ, SIZE_DWORD, 16'h0000, 32'h0);
      post_access(mas_pkg::CMD_WRITE, mas_pkg::SIZE_WORD, 16'hFFFF, 32'h1234_5678);
      post_access(CMD_READ, SIZE_CODE3, 16'hFFFE, 32'h0);
      post_access(mas_pkg::CMD_WRITE, mas_pkg::SIZE_BYTE, 16'h1234, 32'h0000_00A5);
      post_access(CMD_READ, mas_pkg::SIZE_WORD, 16'h1233, 32'h0);
      post_access(mas_pkg::CMD_WRITE, SIZE_CODE3, 16'h7FFE, 32'h8765_4321);
      post_access(CMD_READ, SIZE_DWORD, 16'h7FFE, 32'h0);

      // window 0 read-only inside window 1 read/write, limit at 0x8000
      load_config(17'h08000, 1'b1, 16'h7FFC, 16'h7FFD, 16'h7FF0, 16'h8010,
                  6'((1 << mas_pkg::WC_EN0) | (1 << mas_pkg::WC_RD0) |
                     (1 << mas_pkg::WC_EN1) | (1 << mas_pkg::WC_RD1) |
                     (1 << mas_pkg::WC_WR1)));
      post_access(mas_pkg::CMD_WRITE, SIZE_DWORD, 16'h7FFE, 32'hCAFE_F00D);
      post_access(CMD_READ, SIZE_DWORD, 16'h7FFE, 32'h0);
      post_access(mas_pkg::CMD_WRITE, SIZE_DWORD, 16'h7FFD, 32'h1122_3344);
      post_access(CMD_READ, SIZE_DWORD, 16'h7FFD, 32'h0);
      post_access(CMD_READ, SIZE_DWORD, 16'h8020, 32'h0);
      post_access(CMD_READ, mas_pkg::SIZE_WORD, 16'h7FEF, 32'h0);

      // empty window 0, disabled window 1, limit of one byte, wrapping beats
      load_config(17'd1, 1'b1, 16'h0005, 16'h0004, 16'h0000, 16'hFFFF,
                  6'((1 << mas_pkg::WC_EN0) | (1 << mas_pkg::WC_RD0) |
                     (1 << mas_pkg::WC_WR0) | (1 << mas_pkg::WC_RD1) |
                     (1 << mas_pkg::WC_WR1)));
      post_access(mas_pkg::CMD_WRITE, SIZE_DWORD, 16'hFFFE, 32'hAABB_CCDD);
      post_access(CMD_READ, SIZE_DWORD, 16'hFFFE, 32'h0);
      post_access(CMD_READ, mas_pkg::SIZE_BYTE, 16'h0004, 32'h0);
      load_config(17'd1, 1'b0, 16'h0005, 16'h0004, 16'h0000, 16'hFFFF, 6'h00);
      post_access(CMD_READ, SIZE_CODE3, 16'hFFFE, 32'h0);

      for (ph = 0; ph < PHASES; ph++) begin
         random_config(ph);
         req_burst = (ph % 3 == 0) || ($urandom_range(0, 3) == 0);
         rsp_burst = (ph % 3 == 1) || ($urandom_range(0, 3) == 0);
         hot = 16'($urandom());
         if (ph == PHASES / 2) begin
            req_burst = 1'b1;
            long_hold_ask++;
            for (n = 0; n < 60; n++)
               post_access(CMD_READ, 2'($urandom_range(0, 3)), pick_addr(hot), 32'($urandom()));
         end
         for (n = 0; n < PHASE_BEATS; n++)
            post_access(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_addr(hot),
                        32'($urandom()));
      end

      settle();
      repeat (8) @(posedge clock);
      if (rdata_errors == 0 && rdata_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
